@@ rtl/nsd_pkg.sv @@
// Shared types, codes and helpers for the nixie scan display driver.
// No dependencies; every rtl file refers to this package by scoped names.
package nsd_pkg;

  localparam int TUBES = 4;
  localparam int SLOT_W = 3;

  localparam logic [1:0] EDIT_NONE = 2'd0;
  localparam logic [1:0] EDIT_HOUR = 2'd1;
  localparam logic [1:0] EDIT_MIN  = 2'd2;

  localparam logic VIEW_TIME = 1'b0;
  localparam logic VIEW_TEMP = 1'b1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [7:0] TEMP_MAX = 8'd199;
  localparam logic [3:0] HALF_DIGIT = 4'd5;

  typedef struct packed {
    logic       mode;
    logic       sqw_level;
    logic       view_mode;
    logic [1:0] edit_mode;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [7:0] temp_half;
  } in_t;

  typedef struct packed {
    logic [TUBES-1:0] anode;
    logic [3:0]       digit;
    logic             separator;
  } out_t;

  // broadcast control seen by every cell
  typedef struct packed {
    logic       tick;
    logic       sqw;
    logic       view;
    logic [1:0] edit;
  } ctl_t;

  // scan bus passed along the row of tube cells
  typedef struct packed {
    logic             hit;
    logic [TUBES-1:0] anode;
    logic [3:0]       digit;
  } scan_bus_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd2_t;

  // two-digit BCD of a value below 100; tens by reciprocal multiply (205/2048)
  function automatic bcd2_t bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  tx10;
    bcd2_t       r;
    p    = 15'(v) * 15'd205;
    t    = p[14:11];
    tx10 = 7'(t) * 7'd10;
    r.tens = t;
    r.ones = 4'(v - tx10);
    return r;
  endfunction

endpackage

@@ rtl/nsd_tube_cell.sv @@
// One tube cell of the scan ring: holds a stored digit and the scan token.
// Depends on nsd_pkg.
module nsd_tube_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nsd_pkg::ctl_t       ctl,
  input  logic                load,
  input  logic [3:0]          load_digit,
  input  logic                tok_in,
  output logic                tok_out,
  input  nsd_pkg::scan_bus_t  bus_in,
  output nsd_pkg::scan_bus_t  bus_out
);

  logic       tok_r;
  logic [3:0] digit_r;
  logic       blank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= (IDX == 0);
      digit_r <= '0;
    end else begin
      if (ctl.tick) begin
        tok_r <= tok_in;
      end
      if (load) begin
        digit_r <= load_digit;
      end
    end
  end

  always_comb begin
    blank = 1'b0;
    if (!ctl.sqw) begin
      if (IDX < 2 && ctl.edit == nsd_pkg::EDIT_HOUR) blank = 1'b1;
      if (IDX >= 2 && ctl.edit == nsd_pkg::EDIT_MIN) blank = 1'b1;
    end
    if (IDX == nsd_pkg::TUBES - 1 && ctl.view == nsd_pkg::VIEW_TEMP) blank = 1'b1;
    if (tok_r) begin
      bus_out.hit   = 1'b1;
      bus_out.anode = blank ? '0 : nsd_pkg::TUBES'(1) << IDX;
      bus_out.digit = digit_r;
    end else begin
      bus_out = bus_in;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ rtl/nsd_sep_cell.sv @@
// Separator cell closing the scan ring: token for the fifth slot and lamp state.
// Depends on nsd_pkg.
module nsd_sep_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  nsd_pkg::ctl_t ctl,
  input  logic          tok_in,
  output logic          tok_out,
  output logic          separator
);

  logic tok_r;
  logic sep_r;
  logic sep_nxt;

  always_comb begin
    sep_nxt = sep_r;
    if (ctl.tick && tok_r) begin
      if (ctl.sqw) begin
        sep_nxt = 1'b1;
      end else if (ctl.view == nsd_pkg::VIEW_TIME) begin
        sep_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      sep_r <= 1'b0;
    end else begin
      sep_r <= sep_nxt;
      if (ctl.tick) begin
        tok_r <= tok_in;
      end
    end
  end

  assign tok_out   = tok_r;
  assign separator = sep_r;

endmodule

@@ rtl/nixie_scan_display_driver_unit.sv @@
// Top level of the multiplexed four-tube display driver with separator lamp.
// Depends on nsd_pkg, nsd_tube_cell and nsd_sep_cell.
//
// Takes one item per clock and returns one result per item in the cycle after
// acceptance; the anode, digit and separator registers are the result
// registers, and a new item is taken whenever the pending result is absent
// or is being taken in the same cycle. A load item converts hours/minutes or
// the clamped half-degree temperature into four BCD digits held in the tube
// cells and returns the drive registers unchanged. A tick item passes the
// scan token one step around a ring of four tube cells and a separator cell;
// the token holder drives the anode and digit, or in the fifth slot the lamp.
module nixie_scan_display_driver_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nsd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output nsd_pkg::out_t  out_data
);

  localparam int T = nsd_pkg::TUBES;

  logic                   acc;
  logic                   load;
  logic                   out_valid_r;
  logic                   view_r;
  logic [1:0]             edit_r;
  logic [T-1:0]           anode_r;
  logic [3:0]             digit_r;
  logic                   separator;
  nsd_pkg::ctl_t          ctl;
  logic [3:0]             ld_digit [T];
  logic [7:0]             temp_c;
  nsd_pkg::bcd2_t         hi_bcd;
  nsd_pkg::bcd2_t         lo_bcd;
  logic [T-1:0]           tok;
  logic                   sep_tok;
  nsd_pkg::scan_bus_t     bus [T+1];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign load     = acc && (in_data.mode == nsd_pkg::MODE_LOAD);

  assign ctl.tick = acc && (in_data.mode == nsd_pkg::MODE_TICK);
  assign ctl.sqw  = in_data.sqw_level;
  assign ctl.view = view_r;
  assign ctl.edit = edit_r;

  always_comb begin
    temp_c = (in_data.temp_half > nsd_pkg::TEMP_MAX) ? nsd_pkg::TEMP_MAX : in_data.temp_half;
    if (in_data.view_mode == nsd_pkg::VIEW_TIME) begin
      hi_bcd      = nsd_pkg::bcd2(7'(in_data.hours));
      lo_bcd      = nsd_pkg::bcd2(7'(in_data.minutes));
      ld_digit[0] = hi_bcd.tens;
      ld_digit[1] = hi_bcd.ones;
      ld_digit[2] = lo_bcd.tens;
      ld_digit[3] = lo_bcd.ones;
    end else begin
      hi_bcd      = nsd_pkg::bcd2(temp_c[7:1]);
      lo_bcd      = '0;
      ld_digit[0] = hi_bcd.tens;
      ld_digit[1] = hi_bcd.ones;
      ld_digit[2] = temp_c[0] ? nsd_pkg::HALF_DIGIT : 4'd0;
      ld_digit[3] = lo_bcd.ones;
    end
  end

  assign bus[0] = '0;

  for (genvar i = 0; i < T; i++) begin : g_tube
    nsd_tube_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load       (load),
      .load_digit (ld_digit[i]),
      .tok_in     ((i == 0) ? sep_tok : tok[(i == 0) ? 0 : i-1]),
      .tok_out    (tok[i]),
      .bus_in     (bus[i]),
      .bus_out    (bus[i+1])
    );
  end

  nsd_sep_cell u_sep (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .tok_in    (tok[T-1]),
    .tok_out   (sep_tok),
    .separator (separator)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      view_r      <= nsd_pkg::VIEW_TIME;
      edit_r      <= nsd_pkg::EDIT_NONE;
      anode_r     <= '0;
      digit_r     <= '0;
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        view_r <= in_data.view_mode;
        edit_r <= in_data.edit_mode;
      end
      if (ctl.tick && bus[T].hit) begin
        anode_r <= bus[T].anode;
        digit_r <= bus[T].digit;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.anode     = anode_r;
  assign out_data.digit     = digit_r;
  assign out_data.separator = separator;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for nixie_scan_display_driver_unit: directed loads and scan
// rounds, then random items under three sender/receiver stall mixes, checked in order.
// Depends on nsd_pkg and the driver RTL.
`timescale 1ns / 1ps

module testbench;

  class display_scoreboard;
    logic [nsd_pkg::SLOT_W-1:0] scan_slot;
    logic [3:0]                 tube_digit [nsd_pkg::TUBES];
    logic                       view_sel;
    logic [1:0]                 edit_sel;
    logic [nsd_pkg::TUBES-1:0]  anode_drive;
    logic [3:0]                 digit_drive;
    logic                       sep_lamp;
    nsd_pkg::out_t              pending_drive [$];
    int                         errors;
    int                         loads;
    int                         ticks;
    int                         checked;

    function new();
      scan_slot   = '0;
      foreach (tube_digit[i]) tube_digit[i] = '0;
      view_sel    = nsd_pkg::VIEW_TIME;
      edit_sel    = nsd_pkg::EDIT_NONE;
      anode_drive = '0;
      digit_drive = '0;
      sep_lamp    = 1'b0;
      errors      = 0;
      loads       = 0;
      ticks       = 0;
      checked     = 0;
    endfunction

    function nsd_pkg::out_t advance_display(nsd_pkg::in_t it);
      int unsigned   number;
      int unsigned   t;
      logic          blank;
      nsd_pkg::out_t r;
      if (it.mode == nsd_pkg::MODE_LOAD) begin
        loads++;
        view_sel = it.view_mode;
        edit_sel = it.edit_mode;
        if (view_sel == nsd_pkg::VIEW_TIME) begin
          number = it.hours * 100 + it.minutes;
        end else begin
          t = it.temp_half;
          if (t > nsd_pkg::TEMP_MAX) t = nsd_pkg::TEMP_MAX;
          number = (t >> 1) * 100 + (t & 1) * 50;
        end
        tube_digit[0] = 4'((number / 1000) % 10);
        tube_digit[1] = 4'((number % 1000) / 100);
        tube_digit[2] = 4'((number % 100) / 10);
        tube_digit[3] = 4'(number % 10);
      end else begin
        ticks++;
        if (scan_slot < nsd_pkg::TUBES) begin
          anode_drive = nsd_pkg::TUBES'(1) << scan_slot;
          digit_drive = tube_digit[scan_slot];
          blank = !it.sqw_level &&
                  ((scan_slot < 2 && edit_sel == nsd_pkg::EDIT_HOUR) ||
                   (scan_slot >= 2 && edit_sel == nsd_pkg::EDIT_MIN));
          if (scan_slot == nsd_pkg::TUBES - 1 && view_sel == nsd_pkg::VIEW_TEMP) blank = 1'b1;
          if (blank) anode_drive = '0;
        end else if (it.sqw_level) begin
          sep_lamp = 1'b1;
        end else if (view_sel == nsd_pkg::VIEW_TIME) begin
          sep_lamp = 1'b0;
        end
        scan_slot = (scan_slot >= nsd_pkg::TUBES) ? '0 : scan_slot + 1'b1;
      end
      r.anode     = anode_drive;
      r.digit     = digit_drive;
      r.separator = sep_lamp;
      return r;
    endfunction

    function void note_item(nsd_pkg::in_t it);
      pending_drive.push_back(advance_display(it));
    endfunction

    function void check_result(nsd_pkg::out_t got);
      nsd_pkg::out_t exp;
      if (pending_drive.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      exp = pending_drive.pop_front();
      checked++;
      if (got.anode !== exp.anode) begin
        $error("anode: expected %h, actual %h", exp.anode, got.anode);
        errors++;
      end
      if (got.digit !== exp.digit) begin
        $error("digit: expected %h, actual %h", exp.digit, got.digit);
        errors++;
      end
      if (got.separator !== exp.separator) begin
        $error("separator: expected %b, actual %b", exp.separator, got.separator);
        errors++;
      end
    endfunction

    function int pending();
      return pending_drive.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  nsd_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  nsd_pkg::out_t out_data;

  int send_idle_pct = 16;
  int recv_idle_pct = 68;

  display_scoreboard board = new();

  nixie_scan_display_driver_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(out_data);
      if (in_valid && in_ready) board.note_item(in_data);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(nsd_pkg::in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_load(logic view, logic [1:0] edit, logic [4:0] hr, logic [5:0] mn,
                           logic [7:0] temp);
    nsd_pkg::in_t it;
    it           = '0;
    it.mode      = nsd_pkg::MODE_LOAD;
    it.sqw_level = $urandom_range(0, 1);
    it.view_mode = view;
    it.edit_mode = edit;
    it.hours     = hr;
    it.minutes   = mn;
    it.temp_half = temp;
    send_item(it);
  endtask

  task automatic scan_round(logic [4:0] sqw_bits);
    nsd_pkg::in_t it;
    for (int s = 0; s < 5; s++) begin
      it           = nsd_pkg::in_t'($urandom);
      it.mode      = nsd_pkg::MODE_TICK;
      it.sqw_level = sqw_bits[s];
      send_item(it);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_items(int count);
    nsd_pkg::in_t it;
    for (int n = 0; n < count; n++) begin
      it = nsd_pkg::in_t'({$urandom, $urandom});
      it.mode = ($urandom_range(0, 99) < 15) ? nsd_pkg::MODE_LOAD : nsd_pkg::MODE_TICK;
      if ($urandom_range(0, 9) != 0) begin
        it.hours   = $urandom_range(0, 23);
        it.minutes = $urandom_range(0, 59);
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_load(nsd_pkg::VIEW_TIME, nsd_pkg::EDIT_NONE, 5'd12, 6'd34, 8'd0);
    scan_round(5'b00000);
    send_load(nsd_pkg::VIEW_TIME, nsd_pkg::EDIT_HOUR, 5'd31, 6'd63, 8'hff);
    scan_round(5'b01100);
    send_load(nsd_pkg::VIEW_TEMP, 2'd3, 5'd0, 6'd0, 8'd255);
    scan_round(5'b10000);
    send_load(nsd_pkg::VIEW_TEMP, nsd_pkg::EDIT_MIN, 5'd23, 6'd59, 8'd1);
    scan_round(5'b00000);
    drain();

    random_items(565);
    drain();
    send_idle_pct = 68;
    recv_idle_pct = 16;
    random_items(565);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(565);
    drain();

    $display("Covered %0d loads and %0d scan ticks; %0d results checked in order.",
             board.loads, board.ticks, board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (board.pending() != 0) $error("%0d results never arrived", board.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
